/* hw/rtl/bounded_deque_with_key_search_unit_defines.svh */
// Assertion macros for the bounded deque with key search unit.
`ifndef BOUNDED_DEQUE_WITH_KEY_SEARCH_UNIT_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_KEY_SEARCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define BDQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define BDQ_ASSERT(lbl, expr, msg)
`define BDQ_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* hw/rtl/bdq_pkg.sv */
// Shared types and codes for the bounded deque with key search unit.
`default_nettype none
package bdq_pkg;

    // Operation codes
    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_REAR  = 3'd1;
    localparam logic [2:0] MODE_DEL_FRONT = 3'd2;
    localparam logic [2:0] MODE_DEL_REAR  = 3'd3;
    localparam logic [2:0] MODE_SRCH_FRONT = 3'd4;
    localparam logic [2:0] MODE_SRCH_REAR  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;

    localparam logic [4:0] CAP_RESET = 5'd16;

    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] key;
        logic [7:0]         tag;
    } bdq_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         index;
        logic signed [31:0] found_key;
        logic [7:0]         found_tag;
        logic [4:0]         occupancy;
    } bdq_out_t;

    // Broadcast controls for the cell row
    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic cmp;
    } bdq_cell_ctrl_t;

    typedef enum logic {
        BDQ_IDLE,
        BDQ_ENC
    } bdq_state_t;

endpackage
`default_nettype wire

/* hw/rtl/bounded_deque_with_key_search_unit.sv */
// Insert and delete words have their result registered when they are accepted;
// searches pass through the registered cell compare, then the match encoder stage,
// which waits while the output is stalled. One insert/delete word per cycle while
// the output is not stalled; no new word is taken until a search result is posted.
// Reset: occupancy clears to zero and capacity returns to 16; stored records
// stay undefined until written.
`default_nettype none
`include "bounded_deque_with_key_search_unit_defines.svh"
module bounded_deque_with_key_search_unit #(
    parameter int DEPTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire bdq_pkg::bdq_in_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output bdq_pkg::bdq_out_t   out_data,
    input  wire                 cfg_we,
    input  wire logic [4:0]     cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = (CW > 5) ? CW : 5;

    bdq_pkg::bdq_state_t     state_reg;
    bdq_pkg::bdq_state_t     state_next;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [4:0]              cap_reg;
    logic                    rear_reg;
    logic                    out_valid_reg;
    bdq_pkg::bdq_out_t       out_reg;

    logic                    in_fire;
    logic                    out_free;
    logic                    enc_done;
    logic                    is_search;
    logic                    full;
    logic                    empty;
    logic                    rear_load;
    logic [LW-1:0]           lim;
    logic [2:0]              op_status;
    bdq_pkg::bdq_cell_ctrl_t ctrl;

    logic signed [31:0]      cell_key [DEPTH];
    logic [7:0]              cell_tag [DEPTH];
    logic [DEPTH-1:0]        cell_hit;
    logic [DEPTH-1:0]        hitv;
    logic [IW-1:0]           pos;
    bdq_pkg::bdq_out_t       srch_res;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Capacity clipped to the row depth
    always_comb
    begin
        if (LW'(cap_reg) > LW'(DEPTH))
        begin
            lim = LW'(DEPTH);
        end
        else
        begin
            lim = LW'(cap_reg);
        end
    end

    assign full  = (LW'(count_reg) >= lim);
    assign empty = (count_reg == '0);

    // Decode the operation into cell controls and the new count
    always_comb
    begin
        ctrl       = '0;
        rear_load  = 1'b0;
        is_search  = 1'b0;
        count_next = count_reg;
        op_status  = bdq_pkg::ST_OK;
        case (in_data.mode)
            bdq_pkg::MODE_INS_FRONT:
            begin
                if (full)
                begin
                    op_status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.shift_r = in_fire;
                    count_next   = CW'(count_reg + 1'b1);
                end
            end
            bdq_pkg::MODE_INS_REAR:
            begin
                if (full)
                begin
                    op_status = bdq_pkg::ST_FULL;
                end
                else
                begin
                    rear_load  = in_fire;
                    count_next = CW'(count_reg + 1'b1);
                end
            end
            bdq_pkg::MODE_DEL_FRONT:
            begin
                if (empty)
                begin
                    op_status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.shift_l = in_fire;
                    count_next   = CW'(count_reg - 1'b1);
                end
            end
            bdq_pkg::MODE_DEL_REAR:
            begin
                if (empty)
                begin
                    op_status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = CW'(count_reg - 1'b1);
                end
            end
            bdq_pkg::MODE_SRCH_FRONT, bdq_pkg::MODE_SRCH_REAR:
            begin
                is_search = 1'b1;
                ctrl.cmp  = in_fire;
            end
            default:
            begin
                op_status = bdq_pkg::ST_OK;
            end
        endcase
    end

    // Row of cells: records move to a neighbor on front insert and delete
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] lk;
        logic [7:0]         lt;
        logic signed [31:0] rk;
        logic [7:0]         rt;

        if (i == 0)
        begin : g_first
            assign lk = in_data.key;
            assign lt = in_data.tag;
        end
        else
        begin : g_mid
            assign lk = cell_key[i-1];
            assign lt = cell_tag[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rk = cell_key[i];
            assign rt = cell_tag[i];
        end
        else
        begin : g_inner
            assign rk = cell_key[i+1];
            assign rt = cell_tag[i+1];
        end

        bdq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .load      (rear_load && (count_reg == CW'(i))),
            .new_key   (in_data.key),
            .new_tag   (in_data.tag),
            .left_key  (lk),
            .left_tag  (lt),
            .right_key (rk),
            .right_tag (rt),
            .key_q     (cell_key[i]),
            .tag_q     (cell_tag[i]),
            .hit_q     (cell_hit[i])
        );

        // Only held entries may match
        assign hitv[i] = cell_hit[i] && (CW'(i) < count_reg);
    end

    // Encode the first or last match
    always_comb
    begin
        pos = '0;
        if (rear_reg)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                if (hitv[i])
                begin
                    pos = IW'(i);
                end
            end
        end
        else
        begin
            for (int i = DEPTH - 1; i >= 0; i--)
            begin
                if (hitv[i])
                begin
                    pos = IW'(i);
                end
            end
        end
    end

    // Build the search result word
    always_comb
    begin
        srch_res.occupancy = 5'(count_reg);
        if (|hitv)
        begin
            srch_res.status    = bdq_pkg::ST_FOUND;
            srch_res.index     = 4'(pos);
            srch_res.found_key = cell_key[pos];
            srch_res.found_tag = cell_tag[pos];
        end
        else
        begin
            srch_res.status    = bdq_pkg::ST_NOTFOUND;
            srch_res.index     = '0;
            srch_res.found_key = '0;
            srch_res.found_tag = '0;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdq_pkg::BDQ_IDLE:
            begin
                if (in_fire && is_search)
                begin
                    state_next = bdq_pkg::BDQ_ENC;
                end
            end
            bdq_pkg::BDQ_ENC:
            begin
                if (out_free)
                begin
                    state_next = bdq_pkg::BDQ_IDLE;
                end
            end
            default:
            begin
                state_next = bdq_pkg::BDQ_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        enc_done = 1'b0;
        case (state_reg)
            bdq_pkg::BDQ_IDLE:
            begin
                in_ready = out_free;
            end
            bdq_pkg::BDQ_ENC:
            begin
                enc_done = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bdq_pkg::BDQ_IDLE;
            count_reg     <= '0;
            cap_reg       <= bdq_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (in_fire)
            begin
                count_reg <= count_next;
            end
            if ((in_fire && !is_search) || enc_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word and search direction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rear_reg <= (in_data.mode == bdq_pkg::MODE_SRCH_REAR);
        end
        if (in_fire && !is_search)
        begin
            out_reg.status    <= op_status;
            out_reg.index     <= '0;
            out_reg.found_key <= '0;
            out_reg.found_tag <= '0;
            out_reg.occupancy <= 5'(count_next);
        end
        else if (enc_done)
        begin
            out_reg <= srch_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Checks
    `BDQ_ASSERT(a_count_bound, count_reg <= CW'(DEPTH), "occupancy above depth")
    `BDQ_ASSERT_NEXT(a_count_hold, !in_fire, $stable(count_reg), "count moved without a word")
    `BDQ_ASSERT_NEXT(a_enc, in_fire && is_search, state_reg == bdq_pkg::BDQ_ENC, "search not encoded")
    `BDQ_ASSERT_NEXT(a_op_result, in_fire && !is_search, out_valid_reg, "result not posted")

endmodule
`default_nettype wire

/* hw/rtl/bdq_cell.sv */
// One storage cell of the deque row: holds a record and compares its key.
`default_nettype none
module bdq_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire bdq_pkg::bdq_cell_ctrl_t ctrl,
    input  wire                      load,
    input  wire logic signed [31:0]  new_key,
    input  wire logic [7:0]          new_tag,
    input  wire logic signed [31:0]  left_key,
    input  wire logic [7:0]          left_tag,
    input  wire logic signed [31:0]  right_key,
    input  wire logic [7:0]          right_tag,
    output logic signed [31:0]       key_q,
    output logic [7:0]               tag_q,
    output logic                     hit_q
);

    logic signed [31:0] key_reg;
    logic signed [31:0] key_next;
    logic [7:0]         tag_reg;
    logic [7:0]         tag_next;
    logic               hit_reg;
    logic               hit_next;

    // Pick the record for this cycle: from a neighbor, the new word, or hold
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (ctrl.shift_r)
        begin
            key_next = left_key;
            tag_next = left_tag;
        end
        else if (ctrl.shift_l)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
        else if (load)
        begin
            key_next = new_key;
            tag_next = new_tag;
        end
    end

    // Compare the sought key on a search, else hold
    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.cmp)
        begin
            hit_next = (key_reg == new_key);
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign key_q = key_reg;
    assign tag_q = tag_reg;
    assign hit_q = hit_reg;

endmodule
`default_nettype wire

/* test/bdq_result_checker.sv */
// Checker for the deque unit: predicts each result word and compares it with the output.
`timescale 1ns / 100ps
module bdq_result_checker #(
    parameter int DEPTH = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire                in_ready,
    input  bdq_pkg::bdq_in_t   in_data,
    input  wire                out_valid,
    input  wire                out_ready,
    input  bdq_pkg::bdq_out_t  out_data,
    input  wire                cfg_we,
    input  wire [4:0]          cfg_data,
    output int                 fail_count,
    output int                 outstanding
);

    // Shadow copy of the list and the capacity register
    logic signed [31:0] held_key [DEPTH];
    logic [7:0]         held_tag [DEPTH];
    int                 held_count;
    logic [4:0]         cap_reg;

    bdq_pkg::bdq_out_t  pending_results [$];
    bdq_pkg::bdq_out_t  want;
    int                 errors = 0;
    int                 backlog = 0;

    assign fail_count  = errors;
    assign outstanding = backlog;

    // Apply one operation to the shadow list and return the result word it gives
    function automatic bdq_pkg::bdq_out_t apply_deque_op(bdq_pkg::bdq_in_t w);
        bdq_pkg::bdq_out_t r;
        int                lim;
        int                pos;
        bit                hit;
        r        = '0;
        r.status = bdq_pkg::ST_OK;
        lim      = (cap_reg < DEPTH) ? int'(cap_reg) : DEPTH;
        pos      = 0;
        hit      = 1'b0;
        case (w.mode)
            bdq_pkg::MODE_INS_FRONT, bdq_pkg::MODE_INS_REAR:
            begin
                if (held_count >= lim)
                begin
                    r.status = bdq_pkg::ST_FULL;
                end
                else if (w.mode == bdq_pkg::MODE_INS_FRONT)
                begin
                    for (int i = held_count; i > 0; i--)
                    begin
                        held_key[i] = held_key[i - 1];
                        held_tag[i] = held_tag[i - 1];
                    end
                    held_key[0] = w.key;
                    held_tag[0] = w.tag;
                    held_count++;
                end
                else
                begin
                    held_key[held_count] = w.key;
                    held_tag[held_count] = w.tag;
                    held_count++;
                end
            end
            bdq_pkg::MODE_DEL_FRONT, bdq_pkg::MODE_DEL_REAR:
            begin
                if (held_count == 0)
                begin
                    r.status = bdq_pkg::ST_EMPTY;
                end
                else
                begin
                    if (w.mode == bdq_pkg::MODE_DEL_FRONT)
                    begin
                        for (int i = 1; i < held_count; i++)
                        begin
                            held_key[i - 1] = held_key[i];
                            held_tag[i - 1] = held_tag[i];
                        end
                    end
                    held_count--;
                end
            end
            bdq_pkg::MODE_SRCH_FRONT, bdq_pkg::MODE_SRCH_REAR:
            begin
                // first match from the front, or last match for a rear search
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_key[i] == w.key)
                    begin
                        if (!hit || w.mode == bdq_pkg::MODE_SRCH_REAR)
                            pos = i;
                        hit = 1'b1;
                    end
                end
                if (hit)
                begin
                    r.status    = bdq_pkg::ST_FOUND;
                    r.index     = 4'(pos);
                    r.found_key = held_key[pos];
                    r.found_tag = held_tag[pos];
                end
                else
                begin
                    r.status = bdq_pkg::ST_NOTFOUND;
                end
            end
            default:
            begin
            end
        endcase
        r.occupancy = 5'(held_count);
        return r;
    endfunction

    // Report one field that differs from its prediction
    function automatic void check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, fname, want_v, got_v);
        end
    endfunction

    // Track config writes, predict on each accepted input word, compare each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            cap_reg    = bdq_pkg::CAP_RESET;
            pending_results.delete();
            backlog <= 0;
        end
        else
        begin
            if (cfg_we)
                cap_reg = cfg_data;
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with none expected, expected nothing actual %h",
                             $time, out_data);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("index", 32'(want.index), 32'(out_data.index));
                    check_field("found_key", want.found_key, out_data.found_key);
                    check_field("found_tag", 32'(want.found_tag), 32'(out_data.found_tag));
                    check_field("occupancy", 32'(want.occupancy), 32'(out_data.occupancy));
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(apply_deque_op(in_data));
            backlog <= pending_results.size();
        end
    end

endmodule

/* test/tb_bounded_deque_with_key_search_unit.sv */
// Testbench top for the deque unit: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 100ps
module tb_bounded_deque_with_key_search_unit;

    localparam int          DEPTH        = 16;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          PHASE_WORDS  = 260;
    localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7 = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    bdq_pkg::bdq_in_t   in_data   = '0;
    logic               out_ready = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [4:0]         cfg_data  = '0;
    wire                in_ready;
    wire                out_valid;
    bdq_pkg::bdq_out_t  out_data;

    int                 fail_count;
    int                 outstanding;
    int                 send_idle_pct = 18;
    int                 recv_idle_pct = 57;
    int                 cycle_cnt     = 0;
    logic signed [31:0] key_pool [8];
    logic [4:0]         phase_cap [8];

    always #5 clk = ~clk;

    bounded_deque_with_key_search_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    bdq_result_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one input word after an optional random gap, hold it until accepted
    task automatic send_word(input bdq_pkg::bdq_in_t w);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Write the capacity register while the unit is idle
    task automatic set_capacity(input logic [4:0] cap);
        wait_drain();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // Build a random word; keys mostly from a small pool so searches hit
    function automatic bdq_pkg::bdq_in_t random_word(bit fill_bias);
        bdq_pkg::bdq_in_t w;
        int               r;
        r     = $urandom_range(0, 99);
        w.tag = 8'($urandom_range(0, 255));
        w.key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 7)] : $urandom;
        if (r < 3)
            w.mode = $urandom_range(0, 1) ? MODE_SPARE_6 : MODE_SPARE_7;
        else if (r < (fill_bias ? 45 : 23))
            w.mode = $urandom_range(0, 1) ? bdq_pkg::MODE_INS_FRONT : bdq_pkg::MODE_INS_REAR;
        else if (r < 60)
            w.mode = $urandom_range(0, 1) ? bdq_pkg::MODE_DEL_FRONT : bdq_pkg::MODE_DEL_REAR;
        else
            w.mode = $urandom_range(0, 1) ? bdq_pkg::MODE_SRCH_FRONT : bdq_pkg::MODE_SRCH_REAR;
        return w;
    endfunction

    initial
    begin
        int words;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'hFFFF_FFFF;
        key_pool[3] = 32'h0000_0000;
        key_pool[4] = 32'h0000_0001;
        key_pool[5] = $urandom;
        key_pool[6] = $urandom;
        key_pool[7] = $urandom;
        phase_cap   = '{5'd16, 5'd0, 5'd1, 5'd31, 5'd5, 5'd17, 5'($urandom_range(0, 31)), 5'd16};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty list: deletes, searches and a spare mode
        send_word('{bdq_pkg::MODE_DEL_FRONT, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_REAR, 32'h0000_0000, 8'hFF});
        send_word('{bdq_pkg::MODE_SRCH_FRONT, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_REAR, 32'h8000_0000, 8'h00});
        send_word('{MODE_SPARE_6, 32'hFFFF_FFFF, 8'hFF});
        // Fill with extreme keys, a duplicate among them
        send_word('{bdq_pkg::MODE_INS_FRONT, 32'h8000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_INS_REAR, 32'h7FFF_FFFF, 8'hFF});
        send_word('{bdq_pkg::MODE_INS_FRONT, 32'hFFFF_FFFF, 8'hA5});
        send_word('{bdq_pkg::MODE_INS_REAR, 32'h8000_0000, 8'h5A});
        send_word('{bdq_pkg::MODE_INS_REAR, 32'h0000_0000, 8'h3C});
        // First and last match of the duplicate, a miss, the rear entry
        send_word('{bdq_pkg::MODE_SRCH_FRONT, 32'h8000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_REAR, 32'h8000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_FRONT, 32'h0001_2345, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_REAR, 32'h0000_0000, 8'h00});
        send_word('{MODE_SPARE_7, 32'h7FFF_FFFF, 8'h81});
        // Shrink from both ends, then search for the removed front key
        send_word('{bdq_pkg::MODE_DEL_FRONT, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_REAR, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_FRONT, 32'hFFFF_FFFF, 8'h00});
        send_word('{bdq_pkg::MODE_SRCH_REAR, 32'h7FFF_FFFF, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_FRONT, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_FRONT, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_REAR, 32'h0000_0000, 8'h00});
        send_word('{bdq_pkg::MODE_DEL_REAR, 32'h0000_0000, 8'h00});

        // Random phases, one capacity each; idling pattern changes by thirds
        for (int ph = 0; ph < 8; ph++)
        begin
            set_capacity(phase_cap[ph]);
            if (ph < 3)
            begin
                send_idle_pct = 18;
                recv_idle_pct = 57;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            words = (phase_cap[ph] == 5'd0) ? 60 : PHASE_WORDS;
            for (int n = 0; n < words; n++)
            begin
                if (n % 100 == 99)
                    wait_drain();
                send_word(random_word(((n / 40) % 2) == 0));
            end
        end

        wait_drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
